// ===== rtl/lss_pkg.sv =====
// ---------------------------------------------------------------------------
// lss_pkg
// Shared types and constants of the Laplacian stencil smoother.
// ---------------------------------------------------------------------------
package lss_pkg;

  localparam int ROW_W       = 16;
  localparam int COL_W       = 11;
  localparam int COEFF_W     = 16;
  localparam int FRAC_BITS   = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int OUT_DEPTH   = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COL_COUNT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_COEFF     = 2'd2;

  localparam logic [ROW_W-1:0]   ROW_COUNT_RST = 16'd5;
  localparam logic [COL_W-1:0]   COL_COUNT_RST = 11'd5;
  localparam logic [COEFF_W-1:0] COEFF_RST     = 16'd6554;

  typedef struct packed {
    logic valid;
    logic last;
  } lss_ctl_t;

endpackage

// ===== rtl/lss_ram.sv =====
// ---------------------------------------------------------------------------
// lss_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module lss_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lss_arith.sv =====
// ---------------------------------------------------------------------------
// lss_arith
// Two-stage scale and accumulate: lap * c, shift out the fraction,
// add the center sample and saturate.
// ---------------------------------------------------------------------------
module lss_arith #(
  parameter int SAMPLE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lss_pkg::lss_ctl_t             ctl_i,
  input  logic signed [SAMPLE_BITS+2:0] lap_i,
  input  logic signed [SAMPLE_BITS-1:0] center_i,
  input  logic [lss_pkg::COEFF_W-1:0]   coeff_i,
  output lss_pkg::lss_ctl_t             ctl_o,
  output logic signed [SAMPLE_BITS-1:0] result_o
);

  localparam int PW = SAMPLE_BITS + 3 + lss_pkg::COEFF_W + 1;
  localparam int SW = SAMPLE_BITS + 4;
  localparam int AW = SAMPLE_BITS + 5;

  lss_pkg::lss_ctl_t             ctl_a_q;
  lss_pkg::lss_ctl_t             ctl_b_q;
  logic signed [PW-1:0]          prod_d;
  logic signed [PW-1:0]          prod_q;
  logic signed [SAMPLE_BITS-1:0] center_a_q;
  logic signed [PW-1:0]          shr_full;
  logic signed [SW-1:0]          shr;
  logic signed [AW-1:0]          sum;
  logic signed [SAMPLE_BITS-1:0] sat_d;
  logic signed [SAMPLE_BITS-1:0] result_q;

  assign prod_d = PW'(lap_i) * PW'($signed({1'b0, coeff_i}));

  assign shr_full = prod_q >>> lss_pkg::FRAC_BITS;
  assign shr      = shr_full[SW-1:0];
  assign sum      = AW'(center_a_q) + AW'(shr);

  always_comb begin
    if (sum[AW-1:SAMPLE_BITS-1] == {(AW-SAMPLE_BITS+1){1'b0}} ||
        sum[AW-1:SAMPLE_BITS-1] == {(AW-SAMPLE_BITS+1){1'b1}}) begin
      sat_d = sum[SAMPLE_BITS-1:0];
    end else if (sum[AW-1]) begin
      sat_d = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      sat_d = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
      ctl_b_q <= '0;
    end else begin
      ctl_a_q <= ctl_i;
      ctl_b_q <= ctl_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q     <= prod_d;
    center_a_q <= center_i;
    result_q   <= sat_d;
  end

  assign ctl_o    = ctl_b_q;
  assign result_o = result_q;

endmodule

// ===== rtl/lss_out_fifo.sv =====
// ---------------------------------------------------------------------------
// lss_out_fifo
// Small result queue between the arithmetic pipeline and the output port.
// ---------------------------------------------------------------------------
module lss_out_fifo #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

endmodule

// ===== rtl/laplacian_stencil_smoother_unit.sv =====
// ---------------------------------------------------------------------------
// laplacian_stencil_smoother_unit
// Five-point Laplacian smoothing of a raster-order grid stream.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+------------------------
//   in      | sink      | in_valid_i / in_stall_o  | sample_i
//   out     | source    | out_valid_o / out_stall_i| smoothed_o, last_of_frame_o
//   cfg     | sink      | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// One sample per cycle while in_stall_o is low; the sample completing a window
// has its line store read at the edge that accepts it, and its result then
// passes stencil sum, multiply, saturate and the result queue.
// The line store RAM is read and written once per item; back-to-back hits
// on one column are forwarded from the window registers.
// After reset a clearing pass over all MAX_COLS addresses zeroes the line
// store; in_stall_o is high during it.
// in_stall_o rises when the result queue plus items in flight fill it.
// ---------------------------------------------------------------------------
module laplacian_stencil_smoother_unit #(
  parameter int MAX_COLS    = 1024,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]       sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]       smoothed_o,
  output logic                                last_of_frame_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lss_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [lss_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int AW    = $clog2(MAX_COLS);
  localparam int CW    = (AW + 1 > lss_pkg::COL_W) ? AW + 1 : lss_pkg::COL_W;
  localparam int RW    = lss_pkg::ROW_W;
  localparam int LW    = SAMPLE_BITS + 3;
  localparam int OCC_W = $clog2(lss_pkg::OUT_DEPTH + 1);

  // configuration
  logic [RW-1:0]                row_count_q;
  logic [lss_pkg::COL_W-1:0]    col_count_q;
  logic [lss_pkg::COEFF_W-1:0]  coeff_q;

  // position and control
  logic [RW-1:0]  row_cnt_q;
  logic [AW-1:0]  col_cnt_q;
  logic           clr_q;
  logic [AW-1:0]  clr_addr_q;
  logic [OCC_W-1:0] occ_q;
  logic [OCC_W-1:0] occ_d;

  logic [CW-1:0]  col_ext;
  logic [CW-1:0]  ecols;
  logic [RW-1:0]  erows;
  logic [CW-1:0]  col_next;
  logic [RW:0]    row_next;
  logic           col_wrap;
  logic           row_wrap;
  logic           acc;
  logic           has_res;
  logic           is_last;
  logic           pop;

  // stage 1
  logic                          s1_valid_q;
  logic                          s1_res_q;
  logic                          s1_last_q;
  logic                          s1_fwd_q;
  logic [AW-1:0]                 s1_addr_q;
  logic signed [SAMPLE_BITS-1:0] s1_sample_q;

  logic [2*SAMPLE_BITS-1:0]      rd_data;
  logic signed [SAMPLE_BITS-1:0] top;
  logic signed [SAMPLE_BITS-1:0] mid;
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [2*SAMPLE_BITS-1:0]      ram_wdata;

  // window: w1 = mid two back, w3/w4/w5 = top/mid/sample one back
  logic signed [SAMPLE_BITS-1:0] w1_q;
  logic signed [SAMPLE_BITS-1:0] w3_q;
  logic signed [SAMPLE_BITS-1:0] w4_q;
  logic signed [SAMPLE_BITS-1:0] w5_q;

  logic signed [LW-1:0]          lap_d;
  logic signed [LW-1:0]          lap_q;
  logic signed [SAMPLE_BITS-1:0] center_q;
  lss_pkg::lss_ctl_t             s2_ctl_q;
  lss_pkg::lss_ctl_t             ar_ctl;
  logic signed [SAMPLE_BITS-1:0] ar_result;
  logic [SAMPLE_BITS:0]          fifo_out;

  // configuration port
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= lss_pkg::ROW_COUNT_RST;
      col_count_q <= lss_pkg::COL_COUNT_RST;
      coeff_q     <= lss_pkg::COEFF_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        lss_pkg::CFG_ROW_COUNT: row_count_q <= cfg_data_i[RW-1:0];
        lss_pkg::CFG_COL_COUNT: col_count_q <= cfg_data_i[lss_pkg::COL_W-1:0];
        lss_pkg::CFG_COEFF:     coeff_q     <= cfg_data_i[lss_pkg::COEFF_W-1:0];
        default: ;
      endcase
    end
  end

  // frame geometry
  always_comb begin
    col_ext = CW'(col_count_q);
    if (col_count_q == '0) begin
      ecols = CW'(1);
    end else if (col_ext > CW'(MAX_COLS)) begin
      ecols = CW'(MAX_COLS);
    end else begin
      ecols = col_ext;
    end
    erows    = (row_count_q == '0) ? RW'(1) : row_count_q;
    col_next = CW'(col_cnt_q) + CW'(1);
    row_next = {1'b0, row_cnt_q} + (RW+1)'(1);
    col_wrap = (col_next >= ecols);
    row_wrap = (row_next >= {1'b0, erows});
    has_res  = (row_cnt_q >= RW'(2)) && (col_cnt_q >= AW'(2));
    is_last  = row_wrap && col_wrap;
  end

  assign in_stall_o = clr_q || (occ_q >= OCC_W'(lss_pkg::OUT_DEPTH));
  assign acc        = in_valid_i && !in_stall_o;
  assign pop        = out_valid_o && !out_stall_i;

  always_comb begin
    occ_d = occ_q;
    if (acc && has_res && !pop) begin
      occ_d = occ_q + OCC_W'(1);
    end else if (!(acc && has_res) && pop) begin
      occ_d = occ_q - OCC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q  <= '0;
      col_cnt_q  <= '0;
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      occ_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_res_q   <= 1'b0;
      s1_last_q  <= 1'b0;
      s1_fwd_q   <= 1'b0;
      s2_ctl_q   <= '0;
      w1_q       <= '0;
      w3_q       <= '0;
      w4_q       <= '0;
      w5_q       <= '0;
    end else begin
      occ_q <= occ_d;
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(MAX_COLS - 1)) begin
          clr_q <= 1'b0;
        end
      end
      if (acc) begin
        if (col_wrap) begin
          col_cnt_q <= '0;
          row_cnt_q <= row_wrap ? '0 : row_next[RW-1:0];
        end else begin
          col_cnt_q <= col_next[AW-1:0];
        end
      end
      s1_valid_q <= acc;
      s1_res_q   <= acc && has_res;
      s1_last_q  <= is_last;
      s1_fwd_q   <= acc && s1_valid_q && (s1_addr_q == col_cnt_q);
      s2_ctl_q.valid <= s1_valid_q && s1_res_q;
      s2_ctl_q.last  <= s1_last_q;
      if (s1_valid_q) begin
        w1_q <= w4_q;
        w3_q <= top;
        w4_q <= mid;
        w5_q <= s1_sample_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_addr_q   <= col_cnt_q;
      s1_sample_q <= sample_i;
    end
    lap_q    <= lap_d;
    center_q <= w4_q;
  end

  // line store: {upper, lower} per column
  assign top = s1_fwd_q ? w4_q : rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign mid = s1_fwd_q ? w5_q : rd_data[SAMPLE_BITS-1:0];

  assign ram_we    = clr_q || s1_valid_q;
  assign ram_waddr = clr_q ? clr_addr_q : s1_addr_q;
  assign ram_wdata = clr_q ? '0 : {mid, s1_sample_q};

  lss_ram #(
    .WIDTH (2 * SAMPLE_BITS),
    .DEPTH (MAX_COLS)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (acc),
    .raddr_i (col_cnt_q),
    .rdata_o (rd_data)
  );

  // up + left + right + down - 4 * center
  assign lap_d = LW'(w3_q) + LW'(w1_q) + LW'(mid) + LW'(w5_q) - (LW'(w4_q) <<< 2);

  lss_arith #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_arith (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (s2_ctl_q),
    .lap_i    (lap_q),
    .center_i (center_q),
    .coeff_i  (coeff_q),
    .ctl_o    (ar_ctl),
    .result_o (ar_result)
  );

  lss_out_fifo #(
    .WIDTH (SAMPLE_BITS + 1),
    .DEPTH (lss_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (ar_ctl.valid),
    .data_i  ({ar_ctl.last, ar_result}),
    .pop_i   (pop),
    .valid_o (out_valid_o),
    .data_o  (fifo_out)
  );

  assign smoothed_o      = fifo_out[SAMPLE_BITS-1:0];
  assign last_of_frame_o = fifo_out[SAMPLE_BITS];

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(lss_pkg::OUT_DEPTH))
    else $error("result reservations exceed queue depth");

  a_fwd_same_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fwd_q |-> s1_valid_q && (s1_addr_q == $past(s1_addr_q)))
    else $error("forward taken without a matching prior write");

  a_clr_no_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(clr_q && s1_valid_q))
    else $error("item in flight during line store clear");

  a_push_reserved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ar_ctl.valid |-> occ_q != '0)
    else $error("result pushed without reservation");

endmodule

// ===== tb/laplacian_stencil_smoother_unit_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// laplacian_stencil_smoother_unit_tb
// Self-checking bench for the five-point Laplacian smoother. Raster grids
// are streamed under many frame sizes and coefficients, including degenerate
// and oversized ones and mid-frame size changes. Each interior result is
// predicted and checked field by field, with random idling on both channels
// and a long output hold-off that backs the block up.
// ---------------------------------------------------------------------------
module laplacian_stencil_smoother_unit_tb;

  localparam int MAX_COLS       = 1024;
  localparam int SAMPLE_BITS    = 32;
  localparam int HALF_PERIOD    = 2;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int REPORT_LIMIT   = 10;
  localparam int RANDOM_ITEMS   = 200;

  localparam logic [lss_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef struct packed {
    sample_t smoothed;
    logic    last;
  } smoothed_t;

  localparam sample_t S_MAX = 32'sh7FFF_FFFF;
  localparam sample_t S_MIN = 32'sh8000_0000;
  localparam longint  SAT_HI = 64'sh7FFF_FFFF;
  localparam longint  SAT_LO = -SAT_HI - 1;

  localparam int unsigned IDLE_PCT [4] = '{0, 10, 30, 60};

  localparam sample_t EDGE_GRID [25] = '{
    S_MAX, S_MIN, 32'sd0, -32'sd1, 32'sd1,
    S_MIN, S_MAX, S_MIN, S_MAX, 32'sh0001_0000,
    S_MAX, S_MIN, S_MAX, S_MIN, -32'sh0001_0000,
    32'sd0, S_MAX, S_MIN, S_MAX, 32'sh1234_5678,
    -32'sd1, 32'sd1, 32'sd0, S_MIN, S_MAX
  };

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  sample_t                             in_sample = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  sample_t                             smoothed;
  logic                                last_of_frame;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [lss_pkg::CFG_INDEX_W-1:0]     cfg_index = lss_pkg::CFG_ROW_COUNT;
  logic [lss_pkg::CFG_DATA_W-1:0]      cfg_data = '0;

  // grid predictor state
  sample_t                     row_above [MAX_COLS];
  sample_t                     row_prev  [MAX_COLS];
  sample_t                     left_mid, up_prev, mid_prev, down_prev;
  logic [lss_pkg::ROW_W-1:0]   row_pos;
  logic [9:0]                  col_pos;
  logic [lss_pkg::ROW_W-1:0]   rows_cfg;
  logic [lss_pkg::COL_W-1:0]   cols_cfg;
  logic [lss_pkg::COEFF_W-1:0] coeff_cfg;

  smoothed_t   smoothed_expected [$];
  sample_t     sample_feed [$];
  int unsigned mismatch_count = 0;

  logic        item_taken = 1'b0;
  logic        calm = 1'b0;
  logic        rx_hold_req = 1'b0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_gap = 0;
  int unsigned rx_hold = 0;

  laplacian_stencil_smoother_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .sample_i        (in_sample),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .smoothed_o      (smoothed),
    .last_of_frame_o (last_of_frame),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  task automatic smooth_step(input sample_t s);
    int unsigned erows, ecols, j, r;
    sample_t     above, prev;
    longint      lap, acc;
    smoothed_t   res;
    erows = (rows_cfg == '0) ? 1 : 32'(rows_cfg);
    ecols = (cols_cfg == '0) ? 1 : 32'(cols_cfg);
    if (ecols > MAX_COLS) ecols = MAX_COLS;
    j = 32'(col_pos);
    r = 32'(row_pos);
    above = row_above[j];
    prev  = row_prev[j];
    if (r >= 2 && j >= 2) begin
      lap = longint'(up_prev) + longint'(left_mid) + longint'(prev) + longint'(down_prev)
            - 4 * longint'(mid_prev);
      acc = longint'(mid_prev) + ((lap * longint'(coeff_cfg)) >>> lss_pkg::FRAC_BITS);
      if (acc > SAT_HI) acc = SAT_HI;
      if (acc < SAT_LO) acc = SAT_LO;
      res.smoothed = sample_t'(acc);
      res.last     = (r + 1 >= erows) && (j + 1 >= ecols);
      smoothed_expected.push_back(res);
    end
    left_mid     = mid_prev;
    up_prev      = above;
    mid_prev     = prev;
    down_prev    = s;
    row_above[j] = prev;
    row_prev[j]  = s;
    if (j + 1 >= ecols) begin
      col_pos = '0;
      row_pos = (r + 1 >= erows) ? '0 : (lss_pkg::ROW_W)'(r + 1);
    end else begin
      col_pos = 10'(j + 1);
    end
  endtask

  always @(posedge clk) begin : monitor
    smoothed_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        item_taken = 1'b1;
        smooth_step(in_sample);
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          lss_pkg::CFG_ROW_COUNT: rows_cfg  = cfg_data[lss_pkg::ROW_W-1:0];
          lss_pkg::CFG_COL_COUNT: cols_cfg  = cfg_data[lss_pkg::COL_W-1:0];
          lss_pkg::CFG_COEFF:     coeff_cfg = cfg_data[lss_pkg::COEFF_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (smoothed_expected.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("ERROR: result with none expected: smoothed %h last %b",
                     smoothed, last_of_frame);
        end else begin
          want = smoothed_expected.pop_front();
          if (smoothed !== want.smoothed || last_of_frame !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("ERROR: smoothed exp %h got %h, last exp %b got %b",
                       want.smoothed, smoothed, want.last, last_of_frame);
          end
        end
      end
    end
  end

  always @(negedge clk) begin : sample_driver
    if (!in_valid || item_taken) begin
      item_taken = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (sample_feed.size() > 0) begin
        if (!calm && $urandom_range(99) < tx_idle_pct) begin
          tx_gap = $urandom_range(9);
          in_valid <= 1'b0;
        end else begin
          in_valid  <= 1'b1;
          in_sample <= sample_feed.pop_front();
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : result_receiver
    if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      rx_hold = RX_HOLD_CYCLES;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_stall <= 1'b1;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(99) < rx_idle_pct) begin
      rx_gap = $urandom_range(9);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("laplacian_stencil_smoother_unit: mismatch");
    $finish;
  end

  function automatic sample_t pick_sample(input int unsigned flavor);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 5) return S_MAX;
    if (roll < 10) return S_MIN;
    if (flavor == 0 || roll < 30) return sample_t'($urandom);
    return sample_t'(int'($urandom_range(0, 2097151)) - 1048576);
  endfunction

  task automatic write_reg(input logic [lss_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [lss_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_frame(input logic [15:0] rows, input logic [15:0] cols,
                           input logic [15:0] coeff);
    write_reg(lss_pkg::CFG_ROW_COUNT, rows);
    write_reg(lss_pkg::CFG_COL_COUNT, cols);
    write_reg(lss_pkg::CFG_COEFF, coeff);
  endtask

  // wait until every item is in and every result is out, then let the pipe empty
  task automatic settle();
    do @(negedge clk);
    while (sample_feed.size() != 0 || in_valid || smoothed_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input int unsigned n, input int unsigned flavor,
                           input int unsigned tx_pct, input int unsigned rx_pct);
    @(posedge clk);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (n) sample_feed.push_back(pick_sample(flavor));
    settle();
  endtask

  initial begin : stimulus
    int unsigned rows, cols, coeff_v, er, ec, n, random_items, roll;
    logic [15:0] col_word;
    foreach (row_above[k]) begin
      row_above[k] = '0;
      row_prev[k]  = '0;
    end
    left_mid  = '0;
    up_prev   = '0;
    mid_prev  = '0;
    down_prev = '0;
    row_pos   = '0;
    col_pos   = '0;
    rows_cfg  = lss_pkg::ROW_COUNT_RST;
    cols_cfg  = lss_pkg::COL_COUNT_RST;
    coeff_cfg = lss_pkg::COEFF_RST;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset frame size, extremes on a checkerboard
    @(posedge clk);
    tx_idle_pct = 30;
    rx_idle_pct = 30;
    foreach (EDGE_GRID[k]) sample_feed.push_back(EDGE_GRID[k]);
    settle();

    write_reg(lss_pkg::CFG_COEFF, 16'hFFFF);
    run_phase(25, 0, 10, 10);
    write_reg(lss_pkg::CFG_COEFF, 16'h0000);
    run_phase(25, 0, 0, 30);

    // degenerate sizes give no results
    set_frame(16'd0, 16'd0, 16'd6554);
    run_phase(12, 0, 10, 10);
    set_frame(16'd1, 16'd9, 16'd30000);
    run_phase(20, 1, 10, 10);
    set_frame(16'd2, 16'd7, 16'd30000);
    run_phase(20, 1, 10, 10);
    set_frame(16'd9, 16'd2, 16'd30000);
    run_phase(20, 1, 10, 10);
    write_reg(CFG_UNUSED, 16'hFFFF);
    set_frame(16'd3, 16'd3, 16'd40000);
    run_phase(27, 0, 30, 0);

    // size change mid-frame, position beyond the new bounds
    set_frame(16'd10, 16'd6, 16'd20000);
    run_phase(44, 1, 10, 10);
    set_frame(16'd4, 16'd3, 16'd20000);
    run_phase(30, 1, 10, 10);
    set_frame(16'd3, 16'd1024, 16'd50000);
    run_phase(30, 0, 0, 0);
    set_frame(16'd4, 16'd5, 16'd50000);
    run_phase(40, 0, 10, 10);
    set_frame(16'd65535, 16'd3, 16'd12345);
    run_phase(60, 0, 10, 10);

    // oversized columns saturate to the line store depth; the row position is
    // already past row 2, so a full-width row and the wrap after it give
    // results while the output is held off
    set_frame(16'd65535, 16'd2047, 16'd45000);
    @(posedge clk);
    rx_hold_req = 1'b1;
    run_phase(MAX_COLS + 16, 1, 0, 10);

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      roll = $urandom_range(99);
      if (roll < 10) rows = (roll < 3) ? 0 : (roll < 5) ? 1 : (roll < 8) ? 2 : 65535;
      else rows = $urandom_range(3, 8);
      roll = $urandom_range(99);
      if (roll < 8) cols = $urandom_range(0, 2);
      else cols = $urandom_range(3, 12);
      roll = $urandom_range(99);
      if (roll < 10) coeff_v = 0;
      else if (roll < 20) coeff_v = 16'hFFFF;
      else coeff_v = $urandom_range(16'hFFFF);
      col_word = 16'(cols);
      if ($urandom_range(9) == 0) col_word[15:lss_pkg::COL_W] = 5'($urandom_range(1, 31));
      set_frame(16'(rows), col_word, 16'(coeff_v));
      er = (rows == 0) ? 1 : rows;
      ec = (cols == 0) ? 1 : cols;
      if (rows == 65535) n = $urandom_range(20, 80);
      else begin
        n = er * ec * $urandom_range(1, 3);
        if ($urandom_range(3) == 0) n += $urandom_range(1, 2 * ec);
      end
      run_phase(n, $urandom_range(1), IDLE_PCT[$urandom_range(3)],
                IDLE_PCT[$urandom_range(3)]);
      random_items += n;
    end

    // closing stretch at full rate
    set_frame(16'd5, 16'd5, 16'd6554);
    @(posedge clk);
    calm = 1'b1;
    run_phase(75, 0, 0, 0);

    if (mismatch_count == 0 && smoothed_expected.size() == 0) begin
      $display("laplacian_stencil_smoother_unit: match");
    end else begin
      $display("laplacian_stencil_smoother_unit: mismatch");
    end
    $finish;
  end

endmodule
